// ===== src/u2a_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// u2a_pkg
// Shared types, constants and helpers for the unsigned to ASCII digit
// converter: controller states, digit counts and the character mapping.
// ----------------------------------------------------------------------------
package u2a_pkg;

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_SKIP,
        ST_EMIT
    } u2a_state_t;

    localparam int unsigned VALUE_W    = 32;
    localparam int unsigned DIGIT_W    = 4;
    localparam int unsigned DEC_DIGITS = 10;
    localparam int unsigned HEX_DIGITS = 8;
    localparam int unsigned BUF_W      = DEC_DIGITS * DIGIT_W;
    localparam int unsigned CNT_W      = $clog2(VALUE_W);
    localparam int unsigned REM_W      = $clog2(DEC_DIGITS + 1);

    localparam logic        MODE_DEC   = 1'b0;
    localparam logic        MODE_HEX   = 1'b1;

    localparam logic [6:0]  CHAR_ZERO    = 7'h30;
    localparam logic [6:0]  CHAR_UPPER_A = 7'h41;
    localparam logic [3:0]  DEC_LIMIT    = 4'd10;
    localparam logic [3:0]  DABBLE_MIN   = 4'd5;
    localparam logic [3:0]  DABBLE_ADD   = 4'd3;

    // Map one digit (0..15) to its ASCII character
    function automatic logic [6:0] digit_to_ascii(input logic [3:0] d);
        logic [6:0] ch;
        if (d >= DEC_LIMIT)
        begin
            ch = CHAR_UPPER_A + {3'b000, d - DEC_LIMIT};
        end
        else
        begin
            ch = CHAR_ZERO + {3'b000, d};
        end
        return ch;
    endfunction

    // Double-dabble correction for one BCD digit ahead of the shift
    function automatic logic [3:0] dabble_adjust(input logic [3:0] d);
        logic [3:0] r;
        if (d >= DABBLE_MIN)
        begin
            r = d + DABBLE_ADD;
        end
        else
        begin
            r = d;
        end
        return r;
    endfunction

endpackage : u2a_pkg
`default_nettype wire

// ===== src/unsigned_to_ascii_digits.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// unsigned_to_ascii_digits
// Converts a 32-bit unsigned value to its decimal or hexadecimal ASCII digits,
// most significant first, without leading zeros, one character per transaction.
// ----------------------------------------------------------------------------
// Channel | Signals                              | Direction
// --------+--------------------------------------+----------
// input   | in_valid, in_ready, value, mode      | in
// output  | out_valid, out_ready, ascii_char,last| out
//
// Decimal: after the value is accepted in idle, the bit-serial double-dabble
// converter shifts in all 32 value bits with add-3 correction. Leading zeros
// are then dropped one digit at a time before the digits are presented.
// Hex: the value is loaded straight into the digit shift register, and the
// same zero-drop stage and digit presentation follow.
// One value is handled at a time; in_ready is high only when idle. A stalled
// output holds the current character. Reset returns the controller to idle.
// ----------------------------------------------------------------------------
module unsigned_to_ascii_digits (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [u2a_pkg::VALUE_W-1:0]   value,
    input  wire logic                          mode,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [6:0]                         ascii_char,
    output logic                               last
);
    import u2a_pkg::*;

    u2a_state_t         state_reg, state_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [REM_W-1:0]   rem_reg, rem_next;
    logic [VALUE_W-1:0] bin_reg, bin_next;
    logic [BUF_W-1:0]   dig_reg, dig_next;
    logic [BUF_W-1:0]   dig_adj;
    logic [DIGIT_W-1:0] top_digit;

    // Correct every BCD digit ahead of the next shift
    always_comb
    begin
        for (int i = 0; i < DEC_DIGITS; i++)
        begin
            dig_adj[i*DIGIT_W +: DIGIT_W] = dabble_adjust(dig_reg[i*DIGIT_W +: DIGIT_W]);
        end
    end

    assign top_digit  = dig_reg[BUF_W-1 -: DIGIT_W];
    assign ascii_char = digit_to_ascii(top_digit);
    assign last       = (rem_reg == REM_W'(1));
    assign in_ready   = (state_reg == ST_IDLE);
    assign out_valid  = (state_reg == ST_EMIT);

    // Hold state and datapath registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            rem_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            rem_reg   <= rem_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bin_reg <= bin_next;
        dig_reg <= dig_next;
    end

    // Next state and datapath control
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        rem_next   = rem_reg;
        bin_next   = bin_reg;
        dig_next   = dig_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cnt_next = '0;
                    if (mode == MODE_HEX)
                    begin
                        // Load hex nibbles straight into the top of the buffer
                        dig_next   = {value, {(BUF_W-VALUE_W){1'b0}}};
                        rem_next   = REM_W'(HEX_DIGITS);
                        state_next = ST_SKIP;
                    end
                    else
                    begin
                        bin_next   = value;
                        dig_next   = '0;
                        rem_next   = REM_W'(DEC_DIGITS);
                        state_next = ST_CONV;
                    end
                end
            end
            ST_CONV:
            begin
                // Shift one binary bit into the BCD digits
                dig_next = {dig_adj[BUF_W-2:0], bin_reg[VALUE_W-1]};
                bin_next = {bin_reg[VALUE_W-2:0], 1'b0};
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(VALUE_W-1))
                begin
                    state_next = ST_SKIP;
                end
            end
            ST_SKIP:
            begin
                // Drop leading zeros, keeping at least one digit
                if ((top_digit == '0) && (rem_reg != REM_W'(1)))
                begin
                    dig_next = {dig_reg[BUF_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
                    rem_next = rem_reg - REM_W'(1);
                end
                else
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                // Advance to the next digit once this one is taken
                if (out_ready)
                begin
                    if (rem_reg == REM_W'(1))
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        dig_next = {dig_reg[BUF_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
                        rem_next = rem_reg - REM_W'(1);
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule : unsigned_to_ascii_digits
`default_nettype wire

// ===== src/u2a_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// u2a_checker
// Port-level checks for the digit converter, bound to the top level.
// ----------------------------------------------------------------------------
module u2a_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       in_valid,
    input wire logic       in_ready,
    input wire logic       out_valid,
    input wire logic       out_ready,
    input wire logic [6:0] ascii_char,
    input wire logic       last
);

    // One value at a time: never take input while a character is offered
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input accepted while output pending");

    // A taken value keeps the input closed on the following cycle
    a_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input still open after a transaction");

    // Only decimal digits or upper-case hex letters appear
    a_char_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((ascii_char >= 7'h30 && ascii_char <= 7'h39) ||
                       (ascii_char >= 7'h41 && ascii_char <= 7'h46)))
        else $error("character out of range");

    // The run closes after its final character
    a_run_end: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && last) |=> !out_valid)
        else $error("output continues after last");

    // A stalled character holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(ascii_char) && $stable(last)))
        else $error("stalled output changed");

endmodule : u2a_checker

bind unsigned_to_ascii_digits u2a_checker u_u2a_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .ascii_char (ascii_char),
    .last       (last)
);
`default_nettype wire

// ===== dv/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the unsigned to ASCII digit converter. A short
// table of directed values (zero, extremes, radix boundaries) is followed by
// random values in both radices. Every accepted value is turned into its
// expected character sequence, either spelled out in the table or worked out
// by a local digit predictor, and each output transaction is compared in
// order. Both channels idle at random, and the output side holds off for long
// stretches so that the converter backs up onto its input.
// ----------------------------------------------------------------------------
module tb;

    import u2a_pkg::*;

    localparam int unsigned RANDOM_ITEMS = 240;
    localparam int unsigned LIMIT_CYCLES = 300000;
    localparam int unsigned DRAIN_CYCLES = 100;
    localparam int unsigned LONG_HOLD    = 200;
    localparam logic [6:0]  ASCII_0      = 7'h30;
    localparam logic [6:0]  ASCII_A      = 7'h41;

    // One expected character and its end-of-run flag
    typedef struct packed {
        logic [6:0] ch;
        logic       fin;
    } glyph_t;

    // One directed row; a non-zero text gives the digits as typed
    typedef struct {
        logic [31:0] number;
        logic        radix;
        logic [79:0] text;
    } stim_row_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [31:0] value;
    logic        mode;
    logic        out_valid;
    logic        out_ready;
    logic [6:0]  ascii_char;
    logic        last;

    glyph_t      digits_due[$];
    int          mismatches;
    int unsigned cycle_count;
    int unsigned chars_seen;

    stim_row_t directed [24] = '{
        '{32'd0,          MODE_DEC, "0"},
        '{32'd0,          MODE_HEX, "0"},
        '{32'hFFFF_FFFF,  MODE_DEC, "4294967295"},
        '{32'hFFFF_FFFF,  MODE_HEX, "FFFFFFFF"},
        '{32'd1,          MODE_DEC, "1"},
        '{32'd1,          MODE_HEX, "1"},
        '{32'd9,          MODE_DEC, "9"},
        '{32'd10,         MODE_DEC, "10"},
        '{32'd15,         MODE_HEX, "F"},
        '{32'd16,         MODE_HEX, "10"},
        '{32'd100,        MODE_DEC, "100"},
        '{32'd255,        MODE_HEX, "FF"},
        '{32'hABCD_EF01,  MODE_HEX, "ABCDEF01"},
        '{32'h8000_0000,  MODE_DEC, "2147483648"},
        '{32'h8000_0000,  MODE_HEX, "80000000"},
        '{32'd999999999,  MODE_DEC, "999999999"},
        '{32'd1000000000, MODE_DEC, "1000000000"},
        '{32'h0FFF_FFFF,  MODE_HEX, "FFFFFFF"},
        '{32'h1000_0000,  MODE_HEX, "10000000"},
        '{32'hAAAA_AAAA,  MODE_HEX, "AAAAAAAA"},
        '{32'h7FFF_FFFF,  MODE_DEC, 80'd0},
        '{32'h5555_5555,  MODE_DEC, 80'd0},
        '{32'd12345,      MODE_DEC, 80'd0},
        '{32'h0012_3C4D,  MODE_HEX, 80'd0}
    };

    unsigned_to_ascii_digits DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .value      (value),
        .mode       (mode),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .ascii_char (ascii_char),
        .last       (last)
    );

    // Free-running clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Abort a hung run
    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > LIMIT_CYCLES)
            begin
                $display("unsigned_to_ascii_digits regression: fail");
                $finish;
            end
        end
    end

    // Predict the digits of one value, most significant first
    function automatic void queue_digits(input logic [31:0] number, input logic radix);
        logic [31:0] rest;
        logic [31:0] base;
        logic [3:0]  digit;
        logic [6:0]  rev [10];
        int          n;
        rest = number;
        base = (radix == MODE_HEX) ? 32'd16 : 32'd10;
        n    = 0;
        do
        begin
            digit  = 4'(rest % base);
            rev[n] = (digit >= 4'd10) ? ASCII_A + 7'(digit - 4'd10) : ASCII_0 + 7'(digit);
            n++;
            rest   = rest / base;
        end
        while (rest != 0);
        for (int k = n - 1; k >= 0; k--)
        begin
            digits_due.push_back(glyph_t'{ch: rev[k], fin: (k == 0)});
        end
    endfunction

    // Queue digits typed into the table, skipping the empty leading bytes
    function automatic void queue_spelled(input logic [79:0] text);
        for (int i = 9; i >= 0; i--)
        begin
            if (text[i*8 +: 8] != 8'h00)
            begin
                digits_due.push_back(glyph_t'{ch: text[i*8 +: 7], fin: (i == 0)});
            end
        end
    endfunction

    // Offer one value after an idle gap and hold it until the converter takes it
    task automatic offer(input logic [31:0] number, input logic radix,
                         input logic [79:0] text, input int unsigned gap);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        value    <= number;
        mode     <= radix;
        do @(posedge clk); while (!in_ready);
        if (text != 80'd0)
            queue_spelled(text);
        else
            queue_digits(number, radix);
    endtask

    // Random value with a spread of digit counts
    function automatic logic [31:0] pick_number(input logic radix);
        logic [31:0] power;
        int unsigned sel;
        sel = $urandom_range(0, 9);
        unique case (sel)
            0, 1, 2, 3: return $urandom;
            4, 5, 6:    return $urandom >> $urandom_range(0, 31);
            7:
            begin
                // Land on or just below a power of the radix
                power = 32'd1;
                repeat ($urandom_range(0, (radix == MODE_HEX) ? 7 : 9))
                    power = power * ((radix == MODE_HEX) ? 32'd16 : 32'd10);
                return power - 32'($urandom_range(0, 1));
            end
            8:          return 32'($urandom_range(0, 20));
            default:    return 32'hFFFF_FFFF - 32'($urandom_range(0, 20));
        endcase
    endfunction

    // Stimulus: reset, directed table, random values, then drain
    initial
    begin
        logic [31:0] number;
        logic        radix;
        int unsigned gap;
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        value      = '0;
        mode       = MODE_DEC;
        mismatches = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed[i])
        begin
            offer(directed[i].number, directed[i].radix, directed[i].text,
                  $urandom_range(0, 6));
        end

        for (int unsigned i = 0; i < RANDOM_ITEMS; i++)
        begin
            radix  = 1'($urandom_range(0, 1));
            number = pick_number(radix);
            // Back-to-back stretch every third block of items
            gap    = ((i / 24) % 3 == 2) ? 0 : $urandom_range(0, 6);
            offer(number, radix, 80'd0, gap);
        end
        in_valid <= 1'b0;

        while (digits_due.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("unsigned_to_ascii_digits regression: pass");
        else
            $display("unsigned_to_ascii_digits regression: fail");
        $finish;
    end

    // Output side: random stalls, long holds, and in-order character check
    initial
    begin
        glyph_t      want;
        int unsigned hold;
        out_ready  = 1'b0;
        chars_seen = 0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (chars_seen == 60 || chars_seen == 700)
                hold = LONG_HOLD;
            else if ((chars_seen / 40) % 3 == 1)
                hold = 0;
            else
                hold = $urandom_range(0, 6);
            if (hold > 0)
            begin
                out_ready <= 1'b0;
                repeat (hold) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
            chars_seen++;
            if (digits_due.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected character: expected none, actual %h last %b",
                         $time, ascii_char, last);
            end
            else
            begin
                want = digits_due.pop_front();
                if (ascii_char !== want.ch)
                begin
                    mismatches++;
                    $display("%0t: ascii_char mismatch: expected %h, actual %h",
                             $time, want.ch, ascii_char);
                end
                if (last !== want.fin)
                begin
                    mismatches++;
                    $display("%0t: last mismatch: expected %b, actual %b",
                             $time, want.fin, last);
                end
            end
        end
    end

endmodule
